/* design/afp_pkg.sv */
package afp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAN_W     = 21;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Divider geometry: quotient bits carry one extra bit for rounding.
  localparam int QBITS   = 34;
  localparam int DEN_W   = 52;
  localparam int REM_W   = DEN_W + 1;
  localparam int X_W     = 2 * FRAC_BITS + 35;
  localparam int DIV_LAT = QBITS + 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Smallest magnitude that counts as nonzero (above 0.0001).
  localparam int NZ_MIN = (1 << FRAC_BITS) / 10000 + 1;

  localparam logic signed [33:0] ONE34 = 34'(1 << FRAC_BITS);

  localparam logic signed [TAN_W-1:0] RST_L_LEFT  = -21'sd90178;
  localparam logic signed [TAN_W-1:0] RST_L_RIGHT = 21'sd67882;
  localparam logic signed [TAN_W-1:0] RST_L_UP    = 21'sd66689;
  localparam logic signed [TAN_W-1:0] RST_L_DOWN  = -21'sd66689;
  localparam logic signed [TAN_W-1:0] RST_R_LEFT  = -21'sd67882;
  localparam logic signed [TAN_W-1:0] RST_R_RIGHT = 21'sd90178;
  localparam logic signed [TAN_W-1:0] RST_R_UP    = 21'sd66689;
  localparam logic signed [TAN_W-1:0] RST_R_DOWN  = -21'sd66689;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_L_LEFT  = 3'd0,
    REG_L_RIGHT = 3'd1,
    REG_L_UP    = 3'd2,
    REG_L_DOWN  = 3'd3,
    REG_R_LEFT  = 3'd4,
    REG_R_RIGHT = 3'd5,
    REG_R_UP    = 3'd6,
    REG_R_DOWN  = 3'd7
  } afp_reg_e;

  typedef struct packed {
    logic                    ok;
    logic                    rebuilt;
    logic                    use_div;
    logic                    neg_x;
    logic [DATA_W-1:0]       sx_mag;
    logic [DEN_W-1:0]        hsy;
    logic [TAN_W-1:0]        h;
    logic [TAN_W-1:0]        w;
    logic signed [TAN_W:0]   sumx;
    logic signed [TAN_W:0]   sumy;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [33:0]      zn;
    logic signed [33:0]      zd;
  } afp_item_t;

  typedef struct packed {
    logic                     ok;
    logic                     rebuilt;
    logic                     use_div;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } afp_side_t;

  function automatic logic [33:0] abs34(input logic signed [33:0] v);
    abs34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic nonzero(input logic signed [33:0] v);
    nonzero = abs34(v) >= 34'(NZ_MIN);
  endfunction

endpackage

/* design/asymmetric_frustum_projection.sv */
// Each result strobes on done_o after the front stage, the queue and the dividers.
// Throughput: one item per cycle; six 34-stage restoring dividers run side by side.
// Reset (async, active low): tangent registers load their defaults, queue and pipes empty.
// Results cannot be held off: each is shown for one cycle only.
// busy rises only if the front-to-back queue nears full, which a free-running back
// end never allows, so start is taken every cycle.
module asymmetric_frustum_projection import afp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     eye_select_i,
  input  logic signed [DATA_W-1:0] source_scale_x_i,
  input  logic signed [DATA_W-1:0] source_scale_y_i,
  input  logic signed [DATA_W-1:0] source_depth_a_i,
  input  logic signed [DATA_W-1:0] source_depth_b_i,
  output logic                     done_o,
  output logic                     build_ok_o,
  output logic signed [DATA_W-1:0] scale_x_o,
  output logic signed [DATA_W-1:0] scale_y_o,
  output logic signed [DATA_W-1:0] skew_x_o,
  output logic signed [DATA_W-1:0] skew_y_o,
  output logic signed [DATA_W-1:0] depth_a_o,
  output logic signed [DATA_W-1:0] depth_b_o,
  output logic                     depth_rebuilt_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic signed [TAN_W-1:0]  cfg_data_i
);

  logic      accept;
  logic      push;
  logic      q_valid;
  logic      q_full;
  afp_item_t push_item;
  afp_item_t head_item;

  // Take a beat whenever the queue has room.
  assign busy        = q_full;
  assign accept      = start && !q_full;
  assign cfg_ready_o = 1'b1;

  // Front: select the eye's tangents, form products, classify the beat.
  afp_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i         (accept),
    .eye_select_i,
    .source_scale_x_i,
    .source_scale_y_i,
    .source_depth_a_i,
    .source_depth_b_i,
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .push_o           (push),
    .item_o           (push_item)
  );

  // Short queue decouples classification from the divider bank.
  afp_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .valid_o (q_valid),
    .item_o  (head_item),
    .full_o  (q_full)
  );

  // Back: divide, round, saturate and assemble the result beat.
  afp_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (q_valid),
    .item_i  (head_item),
    .done_o,
    .build_ok_o,
    .scale_x_o,
    .scale_y_o,
    .skew_x_o,
    .skew_y_o,
    .depth_a_o,
    .depth_b_o,
    .depth_rebuilt_o
  );

endmodule

/* design/afp_div.sv */
module afp_div import afp_pkg::*; (
  input  logic                     clk_i,
  input  logic [X_W-1:0]           x_i,
  input  logic [DEN_W-1:0]         d_i,
  input  logic                     neg_i,
  output logic signed [DATA_W-1:0] q_o
);

  logic [REM_W-1:0] rem_q  [QBITS+1];
  logic [QBITS-1:0] low_q  [QBITS+1];
  logic [QBITS-1:0] quot_q [QBITS+1];
  logic [DEN_W-1:0] den_q  [QBITS+1];
  logic             neg_q  [QBITS+1];
  logic             ovf_q  [QBITS+1];

  // Quotient would not fit the quotient bits: saturate.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= REM_W'(x_i[X_W-1:QBITS]);
    low_q[0]  <= x_i[QBITS-1:0];
    quot_q[0] <= '0;
    den_q[0]  <= d_i;
    neg_q[0]  <= neg_i;
    ovf_q[0]  <= DEN_W'(x_i[X_W-1:QBITS]) >= d_i;
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [REM_W-1:0] shifted;
    logic             ge;
    assign shifted = {rem_q[s][REM_W-2:0], low_q[s][QBITS-1-s]};
    assign ge      = shifted >= REM_W'(den_q[s]);
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? shifted - REM_W'(den_q[s]) : shifted;
      low_q[s+1]  <= low_q[s];
      quot_q[s+1] <= {quot_q[s][QBITS-2:0], ge};
      den_q[s+1]  <= den_q[s];
      neg_q[s+1]  <= neg_q[s];
      ovf_q[s+1]  <= ovf_q[s];
    end
  end

  logic [QBITS:0]   fr;
  logic [QBITS-1:0] mag;
  logic             big;
  logic signed [DATA_W-1:0] q_d;

  // Round half away from zero, then saturate.
  always_comb begin
    fr  = (QBITS+1)'(quot_q[QBITS]) + (QBITS+1)'(1);
    mag = fr[QBITS:1];
    big = ovf_q[QBITS] || (mag >= QBITS'(64'h8000_0000));
    if (big) begin
      q_d = neg_q[QBITS] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg_q[QBITS]) begin
      q_d = -$signed(mag[DATA_W-1:0]);
    end else begin
      q_d = $signed(mag[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    q_o <= q_d;
  end

endmodule

/* design/afp_front.sv */
module afp_front import afp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     eye_select_i,
  input  logic signed [DATA_W-1:0] source_scale_x_i,
  input  logic signed [DATA_W-1:0] source_scale_y_i,
  input  logic signed [DATA_W-1:0] source_depth_a_i,
  input  logic signed [DATA_W-1:0] source_depth_b_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic signed [TAN_W-1:0]  cfg_data_i,
  output logic                     push_o,
  output afp_item_t                item_o
);

  logic signed [TAN_W-1:0] tan_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tan_q[REG_L_LEFT]  <= RST_L_LEFT;
      tan_q[REG_L_RIGHT] <= RST_L_RIGHT;
      tan_q[REG_L_UP]    <= RST_L_UP;
      tan_q[REG_L_DOWN]  <= RST_L_DOWN;
      tan_q[REG_R_LEFT]  <= RST_R_LEFT;
      tan_q[REG_R_RIGHT] <= RST_R_RIGHT;
      tan_q[REG_R_UP]    <= RST_R_UP;
      tan_q[REG_R_DOWN]  <= RST_R_DOWN;
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      tan_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  logic signed [TAN_W-1:0] tl, tr, tu, td;
  logic signed [TAN_W:0]   w_d, h_d, sumx_d, sumy_d;
  logic [33:0]             sy_abs, a_abs;
  logic [DEN_W:0]          hsy_full;
  logic [63:0]             asq_d;

  always_comb begin
    tl = eye_select_i ? tan_q[REG_R_LEFT]  : tan_q[REG_L_LEFT];
    tr = eye_select_i ? tan_q[REG_R_RIGHT] : tan_q[REG_L_RIGHT];
    tu = eye_select_i ? tan_q[REG_R_UP]    : tan_q[REG_L_UP];
    td = eye_select_i ? tan_q[REG_R_DOWN]  : tan_q[REG_L_DOWN];
    w_d    = (TAN_W+1)'(tr) - (TAN_W+1)'(tl);
    h_d    = (TAN_W+1)'(tu) - (TAN_W+1)'(td);
    sumx_d = (TAN_W+1)'(tr) + (TAN_W+1)'(tl);
    sumy_d = (TAN_W+1)'(tu) + (TAN_W+1)'(td);
    sy_abs = abs34(34'(source_scale_y_i));
    a_abs  = abs34(34'(source_depth_a_i));
    hsy_full = (DEN_W+1)'(h_d[TAN_W-1:0] * sy_abs[DATA_W-1:0]);
    asq_d    = a_abs[DATA_W-1:0] * a_abs[DATA_W-1:0];
  end

  logic                     f1_valid_q;
  logic signed [TAN_W:0]    w_q, h_q, sumx_q, sumy_q;
  logic signed [DATA_W-1:0] sx_q, sy_q, a_q, b_q;
  logic [DEN_W-1:0]         hsy_q;
  logic [63:0]              asq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      w_q    <= w_d;
      h_q    <= h_d;
      sumx_q <= sumx_d;
      sumy_q <= sumy_d;
      sx_q   <= source_scale_x_i;
      sy_q   <= source_scale_y_i;
      a_q    <= source_depth_a_i;
      b_q    <= source_depth_b_i;
      hsy_q  <= hsy_full[DEN_W-1:0];
      asq_q  <= asq_d;
    end
  end

  // Classify: reject, depth recovery, near clamp, far test.
  logic signed [33:0] dn, df, b34;
  logic signed [34:0] df2, b35;
  logic signed [65:0] m, t;
  logic               clamp, far1, far2, depth_ok, reject;
  logic [33:0]        sx_abs;

  always_comb begin
    b34  = 34'(b_q);
    dn   = 34'(a_q) - ONE34;
    df   = 34'(a_q) + ONE34;
    df2  = 35'(df) <<< 1;
    b35  = 35'(b_q);
    m    = $signed({2'b00, asq_q}) - (66'sd1 <<< (2 * FRAC_BITS));
    t    = -(66'(b_q) <<< (FRAC_BITS + 1));
    clamp = (dn > 34'sd0) ? (b34 < dn) : (b34 > dn);
    far1  = (df > 34'sd0) ? (b35 > df2) : (b35 < df2);
    far2  = (m > 66'sd0) ? (t > m) : (t < m);
    depth_ok = nonzero(dn) && nonzero(df);
    reject   = (w_q <= 0) || (h_q <= 0) || !nonzero(34'(sx_q)) || !nonzero(34'(sy_q));
    sx_abs   = abs34(34'(sx_q));

    item_o.ok      = !reject;
    item_o.rebuilt = depth_ok && (clamp ? far1 : far2);
    item_o.use_div = depth_ok && clamp && far1;
    item_o.neg_x   = sx_q[DATA_W-1] ^ sy_q[DATA_W-1];
    item_o.sx_mag  = sx_abs[DATA_W-1:0];
    item_o.hsy     = hsy_q;
    item_o.h       = h_q[TAN_W-1:0];
    item_o.w       = w_q[TAN_W-1:0];
    item_o.sumx    = sumx_q;
    item_o.sumy    = sumy_q;
    item_o.a       = a_q;
    item_o.b       = b_q;
    item_o.zn      = df + b34;
    item_o.zd      = df - b34;
  end

  assign push_o = f1_valid_q;

endmodule

/* design/afp_fifo.sv */
module afp_fifo import afp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  afp_item_t item_i,
  output logic      valid_o,
  output afp_item_t item_o,
  output logic      full_o
);

  afp_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   count_q;
  logic              pop;

  // The back end takes the head every cycle it is present.
  assign pop     = (count_q != '0);
  assign valid_o = pop;
  assign item_o  = mem_q[rd_q];
  // Leave room for the item still in the front stage.
  assign full_o  = count_q >= (QPTR_W+1)'(QDEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      count_q <= count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != (QPTR_W+1)'(QDEPTH)))
    else $error("queue overflow");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i && pop) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count lost a pop");

endmodule

/* design/afp_back.sv */
module afp_back import afp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  afp_item_t                item_i,
  output logic                     done_o,
  output logic                     build_ok_o,
  output logic signed [DATA_W-1:0] scale_x_o,
  output logic signed [DATA_W-1:0] scale_y_o,
  output logic signed [DATA_W-1:0] skew_x_o,
  output logic signed [DATA_W-1:0] skew_y_o,
  output logic signed [DATA_W-1:0] depth_a_o,
  output logic signed [DATA_W-1:0] depth_b_o,
  output logic                     depth_rebuilt_o
);

  logic [X_W-1:0]   x_sx, x_sy, x_kx, x_ky, x_za, x_zb;
  logic [DEN_W-1:0] d_sx, d_sy, d_kx, d_ky, d_z;
  logic [33:0]      zd_abs;

  always_comb begin
    zd_abs = abs34(item_i.zd);
    x_sx = X_W'(item_i.sx_mag) << (2 * FRAC_BITS + 2);
    x_sy = X_W'(1) << (2 * FRAC_BITS + 2);
    x_kx = X_W'(abs34(34'(item_i.sumx))) << (FRAC_BITS + 1);
    x_ky = X_W'(abs34(34'(item_i.sumy))) << (FRAC_BITS + 1);
    x_za = X_W'(abs34(item_i.zn)) << (FRAC_BITS + 1);
    x_zb = X_W'(abs34(34'(item_i.b))) << (FRAC_BITS + 2);
    d_sx = item_i.hsy;
    d_sy = DEN_W'(item_i.h);
    d_kx = DEN_W'(item_i.w);
    d_ky = DEN_W'(item_i.h);
    d_z  = DEN_W'(zd_abs);
  end

  logic signed [DATA_W-1:0] q_sx, q_sy, q_kx, q_ky, q_za, q_zb;

  afp_div u_div_sx (.clk_i, .x_i(x_sx), .d_i(d_sx), .neg_i(item_i.neg_x), .q_o(q_sx));
  afp_div u_div_sy (.clk_i, .x_i(x_sy), .d_i(d_sy), .neg_i(1'b0), .q_o(q_sy));
  afp_div u_div_kx (.clk_i, .x_i(x_kx), .d_i(d_kx), .neg_i(item_i.sumx[TAN_W]), .q_o(q_kx));
  afp_div u_div_ky (.clk_i, .x_i(x_ky), .d_i(d_ky), .neg_i(item_i.sumy[TAN_W]), .q_o(q_ky));
  afp_div u_div_za (.clk_i, .x_i(x_za), .d_i(d_z),
                    .neg_i(item_i.zn[33] ^ item_i.zd[33]), .q_o(q_za));
  afp_div u_div_zb (.clk_i, .x_i(x_zb), .d_i(d_z),
                    .neg_i(item_i.b[DATA_W-1] ^ item_i.zd[33]), .q_o(q_zb));

  // Side line carries the flags and pass-through depth alongside the dividers.
  logic      valid_q [DIV_LAT];
  afp_side_t side_q  [DIV_LAT];
  afp_side_t side_d;

  always_comb begin
    side_d.ok      = item_i.ok;
    side_d.rebuilt = item_i.rebuilt;
    side_d.use_div = item_i.use_div;
    side_d.a       = item_i.a;
    side_d.b       = item_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < DIV_LAT; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  afp_side_t last;
  assign last = side_q[DIV_LAT-1];

  always_comb begin
    done_o          = valid_q[DIV_LAT-1];
    build_ok_o      = last.ok;
    scale_x_o       = last.ok ? q_sx : '0;
    scale_y_o       = last.ok ? q_sy : '0;
    skew_x_o        = last.ok ? q_kx : '0;
    skew_y_o        = last.ok ? q_ky : '0;
    depth_a_o       = !last.ok ? '0 : (last.use_div ? q_za : last.a);
    depth_b_o       = !last.ok ? '0 : (last.use_div ? q_zb : last.b);
    depth_rebuilt_o = last.ok && last.rebuilt;
  end

endmodule

/* tb/sv/asymmetric_frustum_projection_test.sv */
`timescale 1ns / 100ps

module asymmetric_frustum_projection_test;
  import afp_pkg::*;

  typedef struct {
    bit     eye;
    longint sx, sy, a, b;
  } frustum_req_t;

  typedef struct {
    bit     ok;
    longint scale_x, scale_y, skew_x, skew_y, depth_a, depth_b;
    bit     rebuilt;
  } frustum_terms_t;

  // Tracks tangent registers, predicts frustum terms, checks each result in order.
  class frustum_scoreboard;
    longint tan_reg[NUM_REGS];
    frustum_terms_t pending_terms[$];
    int fails;
    int n_built, n_rejected, n_rebuilt, n_pass;

    function new();
      tan_reg[REG_L_LEFT]  = RST_L_LEFT;
      tan_reg[REG_L_RIGHT] = RST_L_RIGHT;
      tan_reg[REG_L_UP]    = RST_L_UP;
      tan_reg[REG_L_DOWN]  = RST_L_DOWN;
      tan_reg[REG_R_LEFT]  = RST_R_LEFT;
      tan_reg[REG_R_RIGHT] = RST_R_RIGHT;
      tan_reg[REG_R_UP]    = RST_R_UP;
      tan_reg[REG_R_DOWN]  = RST_R_DOWN;
      fails = 0;
    endfunction

    function void write_reg(int idx, logic signed [TAN_W-1:0] val);
      if (idx < NUM_REGS) tan_reg[idx] = longint'(val);
    endfunction

    static function bit above_eps(longint v);
      longint m;
      m = v < 0 ? -v : v;
      return m * 10000 > (longint'(1) << FRAC_BITS);
    endfunction

    // Rounded |num| * 2^sh / |den|, ties away from zero, capped at 2^40.
    static function longint unsigned mag_quot(longint unsigned num, longint unsigned den,
                                              int sh);
      longint unsigned cap, q, r;
      cap = longint'(1) << 40;
      if (den == 0) return cap;
      q = num / den;
      r = num % den;
      for (int i = 0; i < sh; i++) begin
        if (q >= cap) return cap;
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      if (r >= den - r) q++;
      return q > cap ? cap : q;
    endfunction

    static function longint quot_sat(longint num, longint den, int sh);
      longint s;
      bit neg;
      neg = (num < 0) != (den < 0);
      s = longint'(mag_quot(num < 0 ? -num : num, den < 0 ? -den : den, sh));
      if (neg) s = -s;
      if (s > 64'sd2147483647) return 64'sd2147483647;
      if (s < -64'sd2147483648) return -64'sd2147483648;
      return s;
    endfunction

    function void note(frustum_req_t r);
      frustum_terms_t e;
      longint one, tl, tr, tu, td, w, h, dn, df, m, t, d;
      bit near_clamp, far_ok;
      one = longint'(1) << FRAC_BITS;
      tl = tan_reg[r.eye ? REG_R_LEFT : REG_L_LEFT];
      tr = tan_reg[r.eye ? REG_R_RIGHT : REG_L_RIGHT];
      tu = tan_reg[r.eye ? REG_R_UP : REG_L_UP];
      td = tan_reg[r.eye ? REG_R_DOWN : REG_L_DOWN];
      w = tr - tl;
      h = tu - td;
      e = '{default: 0};
      if (w <= 0 || h <= 0 || !above_eps(r.sx) || !above_eps(r.sy)) begin
        n_rejected++;
        pending_terms.push_back(e);
        return;
      end
      e.depth_a = r.a;
      e.depth_b = r.b;
      dn = r.a - one;
      df = r.a + one;
      if (above_eps(dn) && above_eps(df)) begin
        near_clamp = dn > 0 ? (r.b < dn) : (r.b > dn);
        if (near_clamp) begin
          far_ok = df > 0 ? (r.b > 2 * df) : (r.b < 2 * df);
          if (far_ok) begin
            d = df - r.b;
            e.depth_a = quot_sat(df + r.b, d, FRAC_BITS);
            e.depth_b = quot_sat(2 * r.b, d, FRAC_BITS);
            e.rebuilt = 1;
          end
        end else begin
          m = r.a * r.a - one * one;
          t = -2 * one * r.b;
          e.rebuilt = m > 0 ? (t > m) : (t < m);
        end
      end
      e.ok = 1;
      e.scale_x = quot_sat(2 * r.sx, h * r.sy, 2 * FRAC_BITS);
      e.scale_y = quot_sat(2, h, 2 * FRAC_BITS);
      e.skew_x = quot_sat(tr + tl, w, FRAC_BITS);
      e.skew_y = quot_sat(tu + td, h, FRAC_BITS);
      n_built++;
      if (e.rebuilt) n_rebuilt++;
      else n_pass++;
      pending_terms.push_back(e);
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check(frustum_terms_t got);
      frustum_terms_t e;
      if (pending_terms.size() == 0) begin
        $error("result beat with no item outstanding");
        fails++;
        return;
      end
      e = pending_terms.pop_front();
      field("build_ok", e.ok, got.ok);
      field("scale_x", e.scale_x, got.scale_x);
      field("scale_y", e.scale_y, got.scale_y);
      field("skew_x", e.skew_x, got.skew_x);
      field("skew_y", e.skew_y, got.skew_y);
      field("depth_a", e.depth_a, got.depth_a);
      field("depth_b", e.depth_b, got.depth_b);
      field("depth_rebuilt", e.rebuilt, got.rebuilt);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic eye_select_i = 1'b0;
  logic signed [DATA_W-1:0] source_scale_x_i = '0;
  logic signed [DATA_W-1:0] source_scale_y_i = '0;
  logic signed [DATA_W-1:0] source_depth_a_i = '0;
  logic signed [DATA_W-1:0] source_depth_b_i = '0;
  logic done_o, build_ok_o, depth_rebuilt_o;
  logic signed [DATA_W-1:0] scale_x_o, scale_y_o, skew_x_o, skew_y_o, depth_a_o, depth_b_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic signed [TAN_W-1:0] cfg_data_i = '0;

  frustum_scoreboard sb = new();
  bit allow_gaps;

  always #5 clk_i = ~clk_i;

  asymmetric_frustum_projection uut (.*);

  // Note accepted beats and check results from pre-edge values.
  always @(posedge clk_i) begin
    frustum_req_t r;
    frustum_terms_t got;
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.write_reg(int'(cfg_index_i), cfg_data_i);
    if (rst_ni && start && !busy) begin
      r.eye = eye_select_i;
      r.sx = source_scale_x_i;
      r.sy = source_scale_y_i;
      r.a = source_depth_a_i;
      r.b = source_depth_b_i;
      sb.note(r);
    end
    if (rst_ni && done_o) begin
      got.ok = build_ok_o;
      got.scale_x = scale_x_o;
      got.scale_y = scale_y_o;
      got.skew_x = skew_x_o;
      got.skew_y = skew_y_o;
      got.depth_a = depth_a_o;
      got.depth_b = depth_b_o;
      got.rebuilt = depth_rebuilt_o;
      sb.check(got);
    end
  end

  // Raise the write and hold it until ready is seen; the caller drops valid.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic signed [TAN_W-1:0] val);
    bit hit;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      hit = cfg_ready_o;
      @(posedge clk_i);
    end while (!hit);
  endtask

  // Load all eight tangents (l/r/u/d per eye), plus a stray write to an unused index.
  task automatic load_tangents(longint lt[4], longint rt[4]);
    afp_reg_e r;
    for (int i = 0; i < NUM_REGS; i++) begin
      r = afp_reg_e'(i);
      cfg_write({1'b0, r}, TAN_W'(i < 4 ? lt[i] : rt[i - 4]));
    end
    cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, 15)), TAN_W'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the beat until taken; start stays up for the next beat unless a gap is drawn.
  task automatic send(bit eye, longint sx, longint sy, longint a, longint b);
    bit hit;
    start <= 1'b1;
    eye_select_i <= eye;
    source_scale_x_i <= DATA_W'(sx);
    source_scale_y_i <= DATA_W'(sy);
    source_depth_a_i <= DATA_W'(a);
    source_depth_b_i <= DATA_W'(b);
    do begin
      @(negedge clk_i);
      hit = !busy;
      @(posedge clk_i);
    end while (!hit);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_terms.size() != 0) @(posedge clk_i);
  endtask

  function automatic longint to_fix(real v);
    real s;
    s = v * 65536.0;
    if (s > 2147483647.0) return 64'sd2147483647;
    if (s < -2147483648.0) return -64'sd2147483648;
    return longint'($rtoi(s));
  endfunction

  // Build a frustum from a near/far pair, at times inverted, and random source scales.
  task automatic send_frustum();
    real n, f, sx, sy;
    n = 0.01 + $urandom_range(0, 5000) / 1000.0;
    f = n + ($urandom_range(0, 9) == 0 ? -0.5 : $urandom_range(0, 200000) / 100.0) + 0.001;
    sx = 0.3 + $urandom_range(0, 3000) / 1000.0;
    sy = 0.3 + $urandom_range(0, 3000) / 1000.0;
    if ($urandom_range(0, 15) == 0) sx = -sx;
    if ($urandom_range(0, 15) == 0) sy = -sy;
    send($urandom_range(0, 1), to_fix(sx), to_fix(sy), to_fix((n + f) / (n - f)),
         to_fix(2.0 * n * f / (n - f)));
  endtask

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) send_frustum();
      else send($urandom_range(0, 1), int'($urandom), int'($urandom), int'($urandom),
                int'($urandom));
    end
  endtask

  function automatic longint rand_tan();
    return longint'($urandom_range(0, 1048576)) - 524288;
  endfunction

  initial begin
    longint lt[4], rt[4];
    longint one;
    one = 65536;
    allow_gaps = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats on the reset tangents.
    send(0, 98304, 131072, -66846, -13120);         // near below one: clamped rebuild
    send(1, 98304, 131072, to_fix(-1.5), to_fix(-5.0)); // near above one: values kept
    send(0, 98304, 131072, one, -13120);             // A - 1 too small: pass through
    send(1, 98304, 131072, -one, -13120);            // A + 1 too small: pass through
    send(0, 98304, 131072, to_fix(-3.0), to_fix(-2.0)); // far not beyond near + 1
    send(1, 0, 131072, -66846, -13120);              // zero x scale: rejected
    send(0, 98304, 6, -66846, -13120);               // y scale just below epsilon: rejected
    send(1, 7, -7, -66846, -13120);                  // just above epsilon both
    send(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(1, -2147483648, -2147483648, -2147483648, -2147483648);
    send(0, 2147483647, 7, -2147483648, 2147483647);
    send(1, -7, 2147483647, 0, 0);
    send(0, 98304, 131072, 0, -one);
    send(1, 98304, -131072, -one - 1, 2147483647);
    random_items(250);

    // Widest tangents, then hold off until everything is back.
    drain();
    lt = '{-524288, 524288, 524288, -524288};
    rt = '{-524288, 524288, 524288, -524288};
    load_tangents(lt, rt);
    random_items(150);
    drain();
    for (int i = 0; i < 10; i++) send_frustum();

    // Narrowest positive spans: scales saturate.
    drain();
    lt = '{0, 1, 1, 0};
    rt = '{-524288, -524287, 524288, 524287};
    load_tangents(lt, rt);
    random_items(150);

    // Degenerate spans: every item rejected.
    drain();
    lt = '{524288, -524288, 5, 5};
    rt = '{1000, 1000, -524288, 524288};
    load_tangents(lt, rt);
    random_items(100);

    // Random tangents, some of them inverted.
    for (int p = 0; p < 4; p++) begin
      drain();
      lt[0] = -$urandom_range(0, 524288);
      lt[1] = $urandom_range(0, 524288);
      lt[2] = $urandom_range(0, 524288);
      lt[3] = -$urandom_range(0, 524288);
      for (int i = 0; i < 4; i++) rt[i] = p == 3 ? rand_tan() : lt[i ^ 1] * -1;
      load_tangents(lt, rt);
      if (p == 3) allow_gaps = 0;
      random_items(p == 3 ? 520 : 200);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("covered %0d built (%0d depth rebuilt, %0d passed through), %0d rejected",
             sb.n_built, sb.n_rebuilt, sb.n_pass, sb.n_rejected);
    $display("over eight tangent settings including extreme, tiny and inverted spans");
    if (sb.fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
design/afp_pkg.sv
design/afp_div.sv
design/afp_front.sv
design/afp_fifo.sv
design/afp_back.sv
design/asymmetric_frustum_projection.sv
tb/sv/asymmetric_frustum_projection_test.sv
